// ===== hw/rtl/sads_pkg.sv =====
// Shared constants, codes and types for the shared-array dual stack.
`default_nettype none
package sads_pkg;

   // Store geometry
   localparam int DEPTH = 64;
   localparam int SADS_AW = $clog2(DEPTH);
   localparam int SADS_CW = $clog2(DEPTH + 1);
   localparam int SADS_DW = 32;

   // Operation codes
   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_POP  = 2'd1;
   localparam logic [1:0] KIND_PEEK = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // One classified command handed from front to back
   typedef struct packed {
      logic                     is_write;
      logic                     is_read;
      logic [SADS_AW-1:0]       addr;
      logic [SADS_DW-1:0]       wdata;
      logic [1:0]               status;
      logic                     low_empty;
      logic                     high_empty;
      logic                     store_full;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sads_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module sads_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle: write, or registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sads_front.sv =====
// Front end: accepts words, keeps both stack counts, classifies each operation.
`default_nettype none
module sads_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [1:0]                     req_kind,
   input  wire logic                           req_stack_sel,
   input  wire logic signed [sads_pkg::SADS_DW-1:0] req_push_value,
   output      logic                           enq_valid,
   input  wire logic                           enq_ready,
   output      sads_pkg::cmd_type              enq_cmd
);

   logic [sads_pkg::SADS_CW-1:0] low_count_ff, low_count_in;
   logic [sads_pkg::SADS_CW-1:0] high_count_ff, high_count_in;
   logic [sads_pkg::SADS_CW-1:0] sum;
   logic [sads_pkg::SADS_CW-1:0] sum_in;
   logic [sads_pkg::SADS_CW-1:0] cnt;
   logic [sads_pkg::SADS_CW-1:0] addr_wide;
   logic                         full;
   logic                         accept;
   logic                         do_push;
   logic                         do_read;
   logic                         do_pop;
   logic [1:0]                   status;

   assign accept    = req_valid && req_ready;
   assign req_ready = enq_ready;
   assign enq_valid = req_valid;

   // Classification against current counts
   always_comb begin
      sum     = low_count_ff + high_count_ff;
      full    = (sum == sads_pkg::SADS_CW'(sads_pkg::DEPTH));
      cnt     = req_stack_sel ? high_count_ff : low_count_ff;
      do_push = 1'b0;
      do_read = 1'b0;
      do_pop  = 1'b0;
      status  = sads_pkg::ST_OK;
      unique case (req_kind)
         sads_pkg::KIND_PUSH: begin
            if (full) begin
               status = sads_pkg::ST_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
         sads_pkg::KIND_POP, sads_pkg::KIND_PEEK: begin
            if (cnt == '0) begin
               status = sads_pkg::ST_EMPTY;
            end else begin
               do_read = 1'b1;
               do_pop  = (req_kind == sads_pkg::KIND_POP);
            end
         end
         default: begin
         end
      endcase
   end

   // Store address of the touched word
   always_comb begin
      if (do_push) begin
         addr_wide = req_stack_sel
            ? (sads_pkg::SADS_CW'(sads_pkg::DEPTH - 1) - high_count_ff)
            : low_count_ff;
      end else begin
         addr_wide = req_stack_sel
            ? (sads_pkg::SADS_CW'(sads_pkg::DEPTH) - high_count_ff)
            : (low_count_ff - sads_pkg::SADS_CW'(1));
      end
   end

   // Count update
   always_comb begin
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      if (accept && do_push) begin
         if (req_stack_sel) begin
            high_count_in = high_count_ff + sads_pkg::SADS_CW'(1);
         end else begin
            low_count_in = low_count_ff + sads_pkg::SADS_CW'(1);
         end
      end else if (accept && do_pop) begin
         if (req_stack_sel) begin
            high_count_in = high_count_ff - sads_pkg::SADS_CW'(1);
         end else begin
            low_count_in = low_count_ff - sads_pkg::SADS_CW'(1);
         end
      end
      sum_in = low_count_in + high_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff  <= '0;
         high_count_ff <= '0;
      end else begin
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
      end
   end

   // Command word for the back end; flags reflect the state after this step
   always_comb begin
      enq_cmd.is_write   = do_push;
      enq_cmd.is_read    = do_read;
      enq_cmd.addr       = addr_wide[sads_pkg::SADS_AW-1:0];
      enq_cmd.wdata      = req_push_value;
      enq_cmd.status     = status;
      enq_cmd.low_empty  = (low_count_in == '0);
      enq_cmd.high_empty = (high_count_in == '0);
      enq_cmd.store_full = (sum_in == sads_pkg::SADS_CW'(sads_pkg::DEPTH));
   end

`ifndef ASSERT_OFF
   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      (sum <= sads_pkg::SADS_CW'(sads_pkg::DEPTH)))
      else $error("stack counts exceed store depth");
   a_refused_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && status != sads_pkg::ST_OK)
      |=> (low_count_ff == $past(low_count_ff) && high_count_ff == $past(high_count_ff)))
      else $error("refused operation changed a count");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sads_queue.sv =====
// Two-entry command queue between front and back end.
`default_nettype none
module sads_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enq_valid,
   output      logic              enq_ready,
   input  wire sads_pkg::cmd_type enq_cmd,
   output      logic              deq_valid,
   input  wire logic              deq_ready,
   output      sads_pkg::cmd_type deq_cmd
);

   sads_pkg::cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_enq;
   logic        do_deq;

   assign enq_ready = (count_ff != 2'd2);
   assign deq_valid = (count_ff != 2'd0);
   assign deq_cmd   = entry_ff[rd_ptr_ff];
   assign do_enq    = enq_valid && enq_ready;
   assign do_deq    = deq_valid && deq_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_deq ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_enq) - 2'(do_deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         entry_ff[wr_ptr_ff] <= enq_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= 2'd2))
      else $error("queue occupancy out of range");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff)))
      else $error("queue pointers disagree with occupancy");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sads_back.sv =====
// Back end: performs store accesses in order and holds the result word.
`default_nettype none
module sads_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           deq_valid,
   output      logic                           deq_ready,
   input  wire sads_pkg::cmd_type              deq_cmd,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic signed [sads_pkg::SADS_DW-1:0] rsp_read_value,
   output      logic [1:0]                     rsp_status,
   output      logic                           rsp_low_empty,
   output      logic                           rsp_high_empty,
   output      logic                           rsp_store_full
);

   logic                          s1_valid_ff, s1_valid_in;
   sads_pkg::cmd_type             s1_cmd_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [sads_pkg::SADS_DW-1:0]  out_value_ff;
   logic [1:0]                    out_status_ff;
   logic                          out_low_empty_ff;
   logic                          out_high_empty_ff;
   logic                          out_full_ff;
   logic [sads_pkg::SADS_DW-1:0]  rdata;
   logic                          out_free;
   logic                          s1_adv;
   logic                          take;
   logic                          ram_en;

   // Stage handshakes
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign deq_ready = !s1_valid_ff || s1_adv;
   assign take      = deq_valid && deq_ready;
   assign ram_en    = take && (deq_cmd.is_write || deq_cmd.is_read);

   sads_ram #(
      .WIDTH (sads_pkg::SADS_DW),
      .DEPTH (sads_pkg::DEPTH)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (deq_cmd.is_write),
      .addr  (deq_cmd.addr),
      .wdata (deq_cmd.wdata),
      .rdata (rdata)
   );

   always_comb begin
      s1_valid_in  = take || (s1_valid_ff && !s1_adv);
      out_valid_in = s1_adv || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Access stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff <= deq_cmd;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_value_ff      <= s1_cmd_ff.is_read ? rdata : '0;
         out_status_ff     <= s1_cmd_ff.status;
         out_low_empty_ff  <= s1_cmd_ff.low_empty;
         out_high_empty_ff <= s1_cmd_ff.high_empty;
         out_full_ff       <= s1_cmd_ff.store_full;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_low_empty  = out_low_empty_ff;
   assign rsp_high_empty = out_high_empty_ff;
   assign rsp_store_full = out_full_ff;

`ifndef ASSERT_OFF
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && s1_valid_ff) |-> !take)
      else $error("back end took a word with no room downstream");
   a_status_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != sads_pkg::ST_OK) |-> (rsp_read_value == '0))
      else $error("refused operation returned data");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/shared_array_dual_stack_top.sv =====
// Two LIFO stacks in one 64-word store: top level wiring front, queue and back end.
// Path from req accept to rsp_valid: queue entry, store access stage, result register.
// Throughput: one word per cycle while rsp_ready is high, set by the single store port.
// A 2-entry queue and the result register let either side stall without losing words.
// Reset (synchronous, active high) empties both stacks, the queue and the result register;
// store contents are not cleared and are only read after being pushed.
`default_nettype none
module shared_array_dual_stack_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic [1:0]                     req_kind,
   input  wire logic                           req_stack_sel,
   input  wire logic signed [sads_pkg::SADS_DW-1:0] req_push_value,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic signed [sads_pkg::SADS_DW-1:0] rsp_read_value,
   output      logic [1:0]                     rsp_status,
   output      logic                           rsp_low_empty,
   output      logic                           rsp_high_empty,
   output      logic                           rsp_store_full
);

   logic              enq_valid;
   logic              enq_ready;
   sads_pkg::cmd_type enq_cmd;
   logic              deq_valid;
   logic              deq_ready;
   sads_pkg::cmd_type deq_cmd;

   sads_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_stack_sel  (req_stack_sel),
      .req_push_value (req_push_value),
      .enq_valid      (enq_valid),
      .enq_ready      (enq_ready),
      .enq_cmd        (enq_cmd)
   );

   sads_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_ready (enq_ready),
      .enq_cmd   (enq_cmd),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_cmd   (deq_cmd)
   );

   sads_back u_back (
      .clock          (clock),
      .reset          (reset),
      .deq_valid      (deq_valid),
      .deq_ready      (deq_ready),
      .deq_cmd        (deq_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_low_empty  (rsp_low_empty),
      .rsp_high_empty (rsp_high_empty),
      .rsp_store_full (rsp_store_full)
   );

endmodule
`default_nettype wire
